[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// Each macro expects i_clk, and all but ASSERT_NEXT_ALWAYS i_rst_n, in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/nnps_pkg.sv]
// ----------------------------------------------------------------------------
// nnps_pkg
// Types, constants and helpers of the nearest-neighbor plane scaler.
// ----------------------------------------------------------------------------
package nnps_pkg;

    // Parameter defaults
    localparam int FRAME_PIXELS_DEF = 262144;
    localparam int SCALE_BASE_DEF   = 1588635683;

    // Field widths
    localparam int PIX_W       = 8;
    localparam int SRC_SIZE_W  = 13;
    localparam int DST_SIZE_W  = 14;
    localparam int POS_W       = 13;
    localparam int SIDX_W      = 12;
    localparam int ADDR_FULL_W = 25;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int M_TDATA_W   = 40;

    // Size limits
    localparam logic [SRC_SIZE_W-1:0] SRC_MAX = 13'd4096;
    localparam logic [DST_SIZE_W-1:0] DST_MAX = 14'd8192;

    // Request kinds (tuser)
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    // Step select: source width, source height, destination width, height
    localparam logic [1:0] SEL_SW = 2'd0;
    localparam logic [1:0] SEL_SH = 2'd1;
    localparam logic [1:0] SEL_DW = 2'd2;
    localparam logic [1:0] SEL_DH = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       ld_write;    // load transaction accepted
        logic       fetch_start; // fetch accepted: wrap stale counters
        logic       div_start;   // launch the divider
        logic       div_store;   // capture the quotient
        logic       step_mode;   // 1: step division, 0: axis mapping
        logic [1:0] sel;         // step index or axis (bit 0: 0 col, 1 row)
        logic       steps_set;   // cached steps are valid
        logic       mul_en;      // product of (pos+1) and destination step
        logic       addr_en;     // form the store address
        logic       rd_en;       // read the store
        logic       out_load;    // load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic steps_ok;
        logic out_free;
    } t_status;

    // Source size as used: zero reads as one, large values saturate
    function automatic logic [SRC_SIZE_W-1:0] clamp_src(input logic [SRC_SIZE_W-1:0] v);
        logic [SRC_SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SRC_SIZE_W'(1);
        end else if (v > SRC_MAX) begin
            r = SRC_MAX;
        end
        return r;
    endfunction

    // Destination size as used
    function automatic logic [DST_SIZE_W-1:0] clamp_dst(input logic [DST_SIZE_W-1:0] v);
        logic [DST_SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DST_SIZE_W'(1);
        end else if (v > DST_MAX) begin
            r = DST_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/nnps_ram.sv]
// ----------------------------------------------------------------------------
// nnps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/nnps_div.sv]
// ----------------------------------------------------------------------------
// nnps_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnps_div #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quot;
    logic [W-1:0]     r_div;

    logic [W:0]   w_shift;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;

    // One restoring step
    always_comb begin
        w_shift = {r_rem, r_quot[W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/nnps_datapath.sv]
// ----------------------------------------------------------------------------
// nnps_datapath
// Size registers, cached steps, counters, divider, multiplier, frame store
// and the output register of the scaler.
// ----------------------------------------------------------------------------
module nnps_datapath
    import nnps_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int SCALE_BASE   = SCALE_BASE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIX_W-1:0]      o_pixel,
    output logic [POS_W-1:0]      o_col,
    output logic [POS_W-1:0]      o_row,
    output logic                  o_last
);

    localparam int DIV_W  = $clog2(longint'(SCALE_BASE) + 1);
    localparam int RAM_AW = $clog2(FRAME_PIXELS);
    localparam int LP_W   = $clog2(longint'(FRAME_PIXELS) + 1);

    // Size registers
    logic [SRC_SIZE_W-1:0] r_src_w, r_src_h;
    logic [DST_SIZE_W-1:0] r_dst_w, r_dst_h;
    logic [SRC_SIZE_W-1:0] w_sw, w_sh;
    logic [DST_SIZE_W-1:0] w_dw, w_dh;

    // Cached steps
    logic             r_steps_ok;
    logic [DIV_W-1:0] r_sstep_w, r_sstep_h, r_dstep_w, r_dstep_h;

    // Fetch datapath
    logic [POS_W-1:0]       r_col, r_row;
    logic [DIV_W-1:0]       r_prod;
    logic [SIDX_W-1:0]      r_sc, r_sr;
    logic [ADDR_FULL_W-1:0] r_addr;
    logic                   r_addr_ok;
    logic [LP_W-1:0]        r_lp;

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_pix;
    logic [POS_W-1:0] r_ocol, r_orow;
    logic             r_olast;

    logic                          w_div_done;
    logic [DIV_W-1:0]              w_quot;
    logic [DIV_W-1:0]              w_div_a, w_div_b;
    logic [DST_SIZE_W-1:0]         w_pos1;
    logic [DIV_W-1:0]              w_dstep;
    logic [DST_SIZE_W+DIV_W-1:0]   w_prod_full;
    logic [SRC_SIZE_W-1:0]         w_axis_size;
    logic [SIDX_W-1:0]             w_map;
    logic [ADDR_FULL_W-1:0]        w_addr;
    logic                          w_lp_ok;
    logic                          w_out_free;
    logic [PIX_W-1:0]              w_rdata;
    logic [DST_SIZE_W-1:0]         w_col1, w_row1;
    logic [SRC_SIZE_W-1:0]         w_step_size;

    // Sizes as used by the mapping
    assign w_sw = clamp_src(r_src_w);
    assign w_sh = clamp_src(r_src_h);
    assign w_dw = clamp_dst(r_dst_w);
    assign w_dh = clamp_dst(r_dst_h);

    // Configuration writes drop the cached steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= SRC_SIZE_W'(1);
            r_src_h    <= SRC_SIZE_W'(1);
            r_dst_w    <= DST_SIZE_W'(1);
            r_dst_h    <= DST_SIZE_W'(1);
            r_steps_ok <= 1'b0;
        end else if (i_cfg_we) begin
            r_steps_ok <= 1'b0;
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_wdata[SRC_SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_wdata[SRC_SIZE_W-1:0];
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_wdata;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_wdata;
                default: ;
            endcase
        end else if (i_cmd.steps_set) begin
            r_steps_ok <= 1'b1;
        end
    end

    // Divider operand select
    always_comb begin
        case (i_cmd.sel)
            SEL_SW:  w_step_size = w_sw;
            SEL_SH:  w_step_size = w_sh;
            SEL_DW:  w_step_size = w_dw[SRC_SIZE_W-1:0];
            default: w_step_size = w_dh[SRC_SIZE_W-1:0];
        endcase
        // destination sizes up to 8192 fit the 14-bit view below
        if (i_cmd.step_mode) begin
            w_div_a = DIV_W'(SCALE_BASE);
            case (i_cmd.sel)
                SEL_DW:  w_div_b = DIV_W'(w_dw);
                SEL_DH:  w_div_b = DIV_W'(w_dh);
                default: w_div_b = DIV_W'(w_step_size);
            endcase
        end else begin
            w_div_a = r_prod;
            w_div_b = i_cmd.sel[0] ? r_sstep_h : r_sstep_w;
        end
    end

    nnps_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Product (pos+1) * destination step; bounded by SCALE_BASE
    always_comb begin
        w_pos1      = {1'b0, (i_cmd.sel[0] ? r_row : r_col)} + DST_SIZE_W'(1);
        w_dstep     = i_cmd.sel[0] ? r_dstep_h : r_dstep_w;
        w_prod_full = w_pos1 * w_dstep;
    end

    // Quotient clamped to the last source index
    always_comb begin
        w_axis_size = i_cmd.sel[0] ? w_sh : w_sw;
        if (w_quot >= DIV_W'(w_axis_size)) begin
            w_map = SIDX_W'(w_axis_size - SRC_SIZE_W'(1));
        end else begin
            w_map = w_quot[SIDX_W-1:0];
        end
    end

    assign w_addr = ADDR_FULL_W'(r_sr) * ADDR_FULL_W'(w_sw) + ADDR_FULL_W'(r_sc);

    // Step cache, product, mapped indexes and address
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store && i_cmd.step_mode) begin
            case (i_cmd.sel)
                SEL_SW:  r_sstep_w <= w_quot;
                SEL_SH:  r_sstep_h <= w_quot;
                SEL_DW:  r_dstep_w <= w_quot;
                default: r_dstep_h <= w_quot;
            endcase
        end
        if (i_cmd.div_store && !i_cmd.step_mode) begin
            if (i_cmd.sel[0]) begin
                r_sr <= w_map;
            end else begin
                r_sc <= w_map;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod_full[DIV_W-1:0];
        end
        if (i_cmd.addr_en) begin
            r_addr    <= w_addr;
            r_addr_ok <= (w_addr < ADDR_FULL_W'(FRAME_PIXELS));
        end
    end

    // Load pointer
    assign w_lp_ok = (r_lp < LP_W'(FRAME_PIXELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_cmd.ld_write && w_lp_ok) begin
            r_lp <= r_lp + LP_W'(1);
        end
    end

    // Frame store
    nnps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_write && w_lp_ok),
        .i_waddr (r_lp[RAM_AW-1:0]),
        .i_wdata (i_pixel),
        .i_re    (i_cmd.rd_en && r_addr_ok),
        .i_raddr (r_addr[RAM_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Destination counters
    assign w_col1 = {1'b0, r_col} + DST_SIZE_W'(1);
    assign w_row1 = {1'b0, r_row} + DST_SIZE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.fetch_start) begin
            if ({1'b0, r_col} >= w_dw) begin
                r_col <= '0;
            end
            if ({1'b0, r_row} >= w_dh) begin
                r_row <= '0;
            end
        end else if (i_cmd.out_load) begin
            if (w_col1 >= w_dw) begin
                r_col <= '0;
                r_row <= (w_row1 >= w_dh) ? '0 : w_row1[POS_W-1:0];
            end else begin
                r_col <= w_col1[POS_W-1:0];
            end
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pix   <= r_addr_ok ? w_rdata : '0;
            r_ocol  <= r_col;
            r_orow  <= r_row;
            r_olast <= (w_col1 == w_dw) && (w_row1 == w_dh);
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.steps_ok = r_steps_ok;
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pix;
    assign o_col       = r_ocol;
    assign o_row       = r_orow;
    assign o_last      = r_olast;

endmodule

[rtl/nnps_ctrl.sv]
// ----------------------------------------------------------------------------
// nnps_ctrl
// Sequencer of the scaler: accepts transactions and steps a fetch through
// step division if needed, two mapping divisions, address, store read, output.
// ----------------------------------------------------------------------------
module nnps_ctrl
    import nnps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_req_type,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SDIV  = 4'd1;
    localparam logic [3:0] S_SWAIT = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_DWAIT = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.ld_write = 1'b1;
                    end else begin
                        o_cmd.fetch_start = 1'b1;
                        n_sel   = 2'd0;
                        n_state = i_status.steps_ok ? S_MUL : S_SDIV;
                    end
                end
            end
            S_SDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.step_mode = 1'b1;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                o_cmd.step_mode = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == SEL_DH) begin
                        o_cmd.steps_set = 1'b1;
                        n_sel   = 2'd0;
                        n_state = S_MUL;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_SDIV;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel[0]) begin
                        n_sel   = 2'd0;
                        n_state = S_ADDR;
                    end else begin
                        n_sel   = 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_ADDR: begin
                o_cmd.addr_en = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

[rtl/nearest_neighbor_plane_scaler.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_plane_scaler
// Nearest-neighbor scaler for one 8-bit image plane.
// ----------------------------------------------------------------------------
// Usage:
// Slave stream: tuser = 0 loads tdata (a source pixel) into the frame store
// in raster order; loads past the store capacity are dropped. tuser = 1
// fetches the next destination pixel in raster order. Master stream returns
// one transaction per fetch: pixel, column and line, tlast on the final
// pixel of the plane; the position then wraps to the start.
// The user must set sizes through the write port only while the block is
// idle; the block itself does not enforce this. Loads are taken back to
// back. A fetch holds off all transactions until its result is loaded into
// the output register, and the block takes transactions again from the cycle
// in which that result is offered. The fetch runs one division per axis on
// the shared one-bit-per-cycle divider. The first fetch after a size write
// first refills the step cache with four more divisions.
// The finished result waits in an output register; a stalled receiver holds
// it, and the block keeps accepting loads meanwhile, and works through the
// next fetch up to the point of loading that register.
// Reset clears the counters, the load pointer and the step cache and sets
// all sizes to 1; the frame store keeps no reset state.
// ----------------------------------------------------------------------------
module nearest_neighbor_plane_scaler
    import nnps_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int SCALE_BASE   = SCALE_BASE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [7:0] pixel_in
    input  logic [0:0]            i_s_axis_tuser,  // [0] req_type
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,  // [7:0] pixel_out, [20:8] out_col,
                                                   // [33:21] out_row, [39:34] zero
    output logic                  o_m_axis_tlast,  // frame_last
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd             w_cmd;
    t_status          w_status;
    logic [PIX_W-1:0] w_pix;
    logic [POS_W-1:0] w_col, w_row;

    nnps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_req_type (i_s_axis_tuser[0]),
        .o_ready    (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    nnps_datapath #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .SCALE_BASE   (SCALE_BASE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_pixel     (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_pixel     (w_pix),
        .o_col       (w_col),
        .o_row       (w_row),
        .o_last      (o_m_axis_tlast)
    );

    // Pack result fields, lowest first
    assign o_m_axis_tdata = {(M_TDATA_W - PIX_W - 2 * POS_W)'(0), w_row, w_col, w_pix};

endmodule

[rtl/nnps_checker.sv]
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level assertions for the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnps_checker
    import nnps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [0:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    logic w_s_acc;
    logic w_out_wait;
    assign w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_wait = o_m_axis_tvalid && !i_m_axis_tready;

    // A result stays offered until taken
    `ASSERT_NEXT(a_out_hold, w_out_wait, o_m_axis_tvalid)

    // A stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, w_out_wait, $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // A fetch occupies the sequencer
    `ASSERT_NEXT(a_fetch_busy, w_s_acc && (i_s_axis_tuser[0] == REQ_FETCH), !o_s_axis_tready)

    // Loads are taken one per cycle
    `ASSERT_NEXT(a_load_ready, w_s_acc && (i_s_axis_tuser[0] == REQ_LOAD), o_s_axis_tready)

    // Reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind nearest_neighbor_plane_scaler nnps_checker u_checker (.*);

[tb/nnps_result_checker.sv]
// ----------------------------------------------------------------------------
// nnps_result_checker
// Watches the load/fetch stream, the result stream and the size register
// port of the plane scaler. Keeps its own copy of the frame store, the load
// pointer and the destination position, computes the expected pixel for each
// fetch and compares every result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module nnps_result_checker
    import nnps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // load/fetch stream
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] pixel_in
    input  logic [0:0]            i_s_tuser,   // [0] req_type
    // result stream
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,   // [7:0] pixel_out, [20:8] out_col,
                                               // [33:21] out_row, [39:34] zero
    input  logic                  i_m_tlast,   // frame_last
    // size registers
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // status to the testbench top
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANE_BYTES = FRAME_PIXELS_DEF;

    typedef struct packed {
        logic [7:0]  pixel;
        logic [12:0] col;
        logic [12:0] row;
        logic        last;
    } t_scaled_pixel;

    // Mirror of the block state
    bit [7:0]      plane_mem [PLANE_BYTES];
    int unsigned   load_ptr = 0;
    int unsigned   col_pos  = 0;
    int unsigned   row_pos  = 0;
    logic [12:0]   src_w    = 13'd1;
    logic [12:0]   src_h    = 13'd1;
    logic [13:0]   dst_w    = 14'd1;
    logic [13:0]   dst_h    = 14'd1;

    t_scaled_pixel pending_pixels [$];
    int            fail_cnt    = 0;
    int            pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // Size as the block uses it: zero counts as one, big values saturate
    function automatic int unsigned used_size(input int unsigned v, input int unsigned hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Source index nearest to destination index pos along one axis
    function automatic int unsigned nearest_index(input int unsigned pos,
                                                  input int unsigned src_n,
                                                  input int unsigned dst_n);
        longint unsigned src_step;
        longint unsigned dst_step;
        longint unsigned idx;
        src_step = longint'(SCALE_BASE_DEF) / src_n;
        dst_step = longint'(SCALE_BASE_DEF) / dst_n;
        idx = (longint'(pos) + 1) * dst_step / src_step;
        if (idx >= src_n) begin
            idx = src_n - 1;
        end
        return int'(idx);
    endfunction

    // Work out the pixel of the next destination position and advance
    task automatic push_scaled_pixel();
        int unsigned     sw;
        int unsigned     sh;
        int unsigned     dw;
        int unsigned     dh;
        int unsigned     src_col;
        int unsigned     src_row;
        longint unsigned addr;
        t_scaled_pixel   want;
        sw = used_size(src_w, SRC_MAX);
        sh = used_size(src_h, SRC_MAX);
        dw = used_size(dst_w, DST_MAX);
        dh = used_size(dst_h, DST_MAX);
        // a size write may have left the position outside the plane
        if (col_pos >= dw) begin
            col_pos = 0;
        end
        if (row_pos >= dh) begin
            row_pos = 0;
        end
        src_col = nearest_index(col_pos, sw, dw);
        src_row = nearest_index(row_pos, sh, dh);
        addr = longint'(src_row) * sw + src_col;
        // addresses past the store read as zero
        want.pixel = (addr < PLANE_BYTES) ? plane_mem[addr] : 8'h00;
        want.col   = col_pos[12:0];
        want.row   = row_pos[12:0];
        want.last  = (col_pos == dw - 1) && (row_pos == dh - 1);
        pending_pixels.push_back(want);
        col_pos++;
        if (col_pos >= dw) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= dh) begin
                row_pos = 0;
            end
        end
    endtask

    // Compare one result transaction with the oldest expected pixel
    task automatic check_result();
        t_scaled_pixel want;
        if (pending_pixels.size() == 0) begin
            $error("result transaction with nothing expected: tdata %h tlast %b",
                   i_m_tdata, i_m_tlast);
            fail_cnt++;
        end else begin
            want = pending_pixels.pop_front();
            if (i_m_tdata[7:0] !== want.pixel) begin
                $error("pixel_out: expected %0d, actual %0d", want.pixel, i_m_tdata[7:0]);
                fail_cnt++;
            end
            if (i_m_tdata[20:8] !== want.col) begin
                $error("out_col: expected %0d, actual %0d", want.col, i_m_tdata[20:8]);
                fail_cnt++;
            end
            if (i_m_tdata[33:21] !== want.row) begin
                $error("out_row: expected %0d, actual %0d", want.row, i_m_tdata[33:21]);
                fail_cnt++;
            end
            if (i_m_tdata[39:34] !== 6'd0) begin
                $error("tdata padding: expected 0, actual %0d", i_m_tdata[39:34]);
                fail_cnt++;
            end
            if (i_m_tlast !== want.last) begin
                $error("frame_last: expected %0b, actual %0b", want.last, i_m_tlast);
                fail_cnt++;
            end
        end
    endtask

    // Register writes, then the input transaction, then the output one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_ptr = 0;
            col_pos  = 0;
            row_pos  = 0;
            src_w    = 13'd1;
            src_h    = 13'd1;
            dst_w    = 14'd1;
            dst_h    = 14'd1;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_WIDTH:  src_w = i_cfg_wdata[12:0];
                    CFG_SRC_HEIGHT: src_h = i_cfg_wdata[12:0];
                    CFG_DST_WIDTH:  dst_w = i_cfg_wdata[13:0];
                    CFG_DST_HEIGHT: dst_h = i_cfg_wdata[13:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == REQ_FETCH) begin
                    push_scaled_pixel();
                end else if (load_ptr < PLANE_BYTES) begin
                    plane_mem[load_ptr] = i_s_tdata;
                    load_ptr++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
        end
        pending_cnt = pending_pixels.size();
    end

endmodule

[tb/nearest_neighbor_plane_scaler_tb.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_plane_scaler_tb
// Drives loads, fetches and size writes into the plane scaler: a short
// directed run over small planes, a receiver hold-off, random phases over
// small source planes, then extreme sizes and random destination sizes
// with no idling. The checker module predicts and compares; this module
// makes stimulus, keeps a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module nearest_neighbor_plane_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nnps_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 120;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          hold_seq     = 0;
    int unsigned loads_sent   = 0;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_neighbor_plane_scaler uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    nnps_result_checker pixel_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off when requested
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** nearest_neighbor_plane_scaler: FAILED **");
            $finish;
        end
    end

    // One load or fetch transaction; starts and ends on a falling edge
    task automatic send_item(input logic kind, input logic [7:0] pix);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        if (kind == REQ_LOAD) begin
            loads_sent++;
        end
        @(negedge clk);
    endtask

    // Sender pauses until every fetch has returned its pixel
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Write all four size registers once the block is idle
    task automatic set_sizes(input logic [13:0] sw, input logic [13:0] sh,
                             input logic [13:0] dw, input logic [13:0] dh);
        logic [13:0]          vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        vals = '{sw, sh, dw, dh};
        regs = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= regs[i];
            cfg_wdata <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic load_until(input int unsigned count);
        while (loads_sent < count) begin
            send_item(REQ_LOAD, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_mix(input int n, input int fetch_pct);
        repeat (n) begin
            if ($urandom_range(99) < fetch_pct) begin
                send_item(REQ_FETCH, 8'($urandom_range(255)));
            end else begin
                send_item(REQ_LOAD, 8'($urandom_range(255)));
            end
        end
    endtask

    // Mostly small sizes, now and then anything up to rare_hi (zero too)
    function automatic logic [13:0] pick_size(input int common_hi, input int rare_hi);
        if ($urandom_range(3) == 0) begin
            return 14'($urandom_range(rare_hi));
        end
        return 14'($urandom_range(common_hi, 1));
    endfunction

    // Random sizes, then a load/fetch mix. The source plane stays small and
    // is loaded first so that no fetch reads an empty entry; any_size lets
    // the destination sizes take any register value.
    task automatic random_phase(input bit any_size);
        logic [13:0] sw;
        logic [13:0] sh;
        logic [13:0] dw;
        logic [13:0] dh;
        int unsigned need;
        sw = pick_size(6, 24);
        sh = pick_size(6, 24);
        if (any_size) begin
            dw = pick_size(8, 16383);
            dh = pick_size(8, 16383);
        end else begin
            dw = pick_size(8, 40);
            dh = pick_size(8, 40);
        end
        set_sizes(sw, sh, dw, dh);
        need = (sw == 0 ? 1 : sw) * (sh == 0 ? 1 : sh);
        load_until(need);
        run_mix(PHASE_ITEMS, 60);
    endtask

    // Stimulus
    initial begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles often less than the receiver
        snd_idle_pct = 29;
        rcv_idle_pct = 74;

        // 1x1 plane: every fetch is the last pixel, fetch data ignored
        send_item(REQ_LOAD, 8'hFF);
        send_item(REQ_LOAD, 8'h00);
        send_item(REQ_LOAD, 8'h5A);
        send_item(REQ_LOAD, 8'hA5);
        send_item(REQ_FETCH, 8'h00);
        send_item(REQ_FETCH, 8'hFF);
        // 2x2 to 3x3, stopped midway
        set_sizes(14'd2, 14'd2, 14'd3, 14'd3);
        repeat (4) send_item(REQ_FETCH, 8'h00);
        // narrower plane leaves the column counter outside it
        set_sizes(14'd2, 14'd2, 14'd1, 14'd3);
        repeat (3) send_item(REQ_FETCH, 8'h00);
        set_sizes(14'd2, 14'd2, 14'd3, 14'd3);
        repeat (2) send_item(REQ_FETCH, 8'h00);

        // long receiver hold-off while fetches keep coming
        hold_seq = hold_seq + 1;
        repeat (12) send_item(REQ_FETCH, 8'($urandom_range(255)));
        wait_results();

        repeat (3) random_phase(1'b0);

        // the other way round
        snd_idle_pct = 74;
        rcv_idle_pct = 29;
        repeat (3) random_phase(1'b0);

        // no idling
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_until(64);

        // oversized registers: every source address lies past the store
        set_sizes(14'd16383, 14'd16383, 14'd16383, 14'd1);
        run_mix(24, 80);
        // zero sizes and the largest legal ones
        set_sizes(14'd0, 14'd4096, 14'd0, 14'd8192);
        run_mix(40, 80);
        // whole plane over a one-column source, then wrap
        set_sizes(14'd1, 14'd64, 14'd2, 14'd64);
        run_mix(130, 100);

        repeat (3) random_phase(1'b1);

        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** nearest_neighbor_plane_scaler: PASSED **");
        end else begin
            $display("** nearest_neighbor_plane_scaler: FAILED **");
        end
        $finish;
    end

endmodule
